>>> rtl/hsort_pkg.sv
// ----------------------------------------------------------------------------
// hsort_pkg
// Shared constants and types of the heap sort engine: store geometry,
// transfer payloads and the control/result bundles of the compare unit.
// ----------------------------------------------------------------------------
package hsort_pkg;

	// store geometry
	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int CHILD_W      = IDX_W + 1;

	// input item
	typedef struct packed {
		logic signed [DATA_W-1:0] in_value;
		logic                     in_last;
	} in_item_t;

	// result item
	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic                     out_last;
		logic                     out_overflow;
	} out_item_t;

	// compare unit control: first = left child vs held value,
	// second = right child vs winner of first, r_ok = right child in heap
	typedef struct packed {
		logic first;
		logic second;
		logic r_ok;
	} cmp_ctl_t;

	// compare unit result, valid during the second compare
	typedef struct packed {
		logic                     moved;
		logic                     take_r;
		logic signed [DATA_W-1:0] big_value;
	} cmp_res_t;

endpackage

>>> rtl/hsort_ram.sv
// ----------------------------------------------------------------------------
// hsort_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/hsort_cmp.sv
// ----------------------------------------------------------------------------
// hsort_cmp
// Shared signed compare unit of the sift-down walk. One comparator picks the
// largest of the held value and its two children in two steps, left then right.
// ----------------------------------------------------------------------------
module hsort_cmp import hsort_pkg::*; (
	input  logic                     clk,
	input  cmp_ctl_t                 ctl,
	input  logic signed [DATA_W-1:0] rd_data,
	input  logic signed [DATA_W-1:0] hold_value,
	output cmp_res_t                 res
);

	logic signed [DATA_W-1:0] cand_value_q;
	logic                     cand_is_l_q;
	logic signed [DATA_W-1:0] opnd_b;
	logic                     gt;

	// single comparator, operand chosen by step
	assign opnd_b = ctl.first ? hold_value : cand_value_q;
	assign gt     = rd_data > opnd_b;

	// hold the winner of the left compare
	always_ff @(posedge clk) begin
		if (ctl.first) begin
			cand_value_q <= gt ? rd_data : hold_value;
			cand_is_l_q  <= gt;
		end
	end

	// right compare decides the final winner
	always_comb begin
		res.take_r    = ctl.second & ctl.r_ok & gt;
		res.big_value = res.take_r ? rd_data : cand_value_q;
		res.moved     = res.take_r | cand_is_l_q;
	end

endmodule

>>> rtl/heap_sort_engine_core.sv
// Loading: a set of N values loads at one value per cycle. The sort then walks
// each heap level in the RDL, RDR and CMP states, for the build and extraction
// passes alike, with every access going through the single store read port.
// Results leave one at a time, each read from the store and held until taken.
// Throughput: one set at a time; input is stalled from the last item until
// the last result transfers. Reset clears the count, overflow flag and sequencer.
// ----------------------------------------------------------------------------
// heap_sort_engine_core
// Collects signed values into a store, heapsorts them in place with one
// shared compare unit, and emits them in ascending order.
// ----------------------------------------------------------------------------
module heap_sort_engine_core import hsort_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	// sequencer states
	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_BLD  = 4'd1;
	localparam logic [3:0] ST_GETV = 4'd2;
	localparam logic [3:0] ST_RDL  = 4'd3;
	localparam logic [3:0] ST_RDR  = 4'd4;
	localparam logic [3:0] ST_CMP  = 4'd5;
	localparam logic [3:0] ST_XST  = 4'd6;
	localparam logic [3:0] ST_X1   = 4'd7;
	localparam logic [3:0] ST_X2   = 4'd8;
	localparam logic [3:0] ST_ORD  = 4'd9;
	localparam logic [3:0] ST_OLD  = 4'd10;
	localparam logic [3:0] ST_OWT  = 4'd11;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

	logic [3:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         i_q;
	logic [CNT_W-1:0]         hs_q;
	logic [IDX_W-1:0]         pos_q;
	logic                     extract_q;
	logic                     r_ok_q;
	logic signed [DATA_W-1:0] v_q;
	logic                     res_valid_q;
	out_item_t                res_q;

	logic                     we_c;
	logic [IDX_W-1:0]         waddr_c;
	logic [DATA_W-1:0]        wdata_c;
	logic [IDX_W-1:0]         raddr_c;
	logic [DATA_W-1:0]        rdata;
	logic [CHILD_W-1:0]       l_idx;
	logic [CHILD_W-1:0]       r_idx;
	logic [CHILD_W-1:0]       hs_ext;
	logic                     room;
	logic                     in_xfer;
	logic                     out_xfer;
	logic [CNT_W-1:0]         n_next;
	logic [CNT_W-1:0]         i_dec;
	cmp_ctl_t                 cmp_ctl;
	cmp_res_t                 cmp_res;

	assign item_stall   = (state_q != ST_LOAD);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign in_xfer  = item_valid & ~item_stall;
	assign out_xfer = res_valid_q & ~result_stall;
	assign room     = (cnt_q < CNT_MAX);
	assign n_next   = cnt_q + CNT_W'(room);
	assign i_dec    = i_q - CNT_W'(1);

	// child indexes of the current node
	assign l_idx  = {pos_q, 1'b1};
	assign r_idx  = l_idx + CHILD_W'(1);
	assign hs_ext = CHILD_W'(hs_q);

	// compare unit steps
	always_comb begin
		cmp_ctl.first  = (state_q == ST_RDR);
		cmp_ctl.second = (state_q == ST_CMP);
		cmp_ctl.r_ok   = r_ok_q;
	end

	// store port selection
	always_comb begin
		we_c    = 1'b0;
		waddr_c = pos_q;
		wdata_c = v_q;
		raddr_c = '0;
		unique case (state_q)
			ST_LOAD: begin
				we_c    = in_xfer & room;
				waddr_c = cnt_q[IDX_W-1:0];
				wdata_c = item.in_value;
			end
			ST_BLD:  raddr_c = i_dec[IDX_W-1:0];
			ST_RDL: begin
				raddr_c = l_idx[IDX_W-1:0];
				we_c    = (l_idx >= hs_ext);
			end
			ST_RDR:  raddr_c = r_idx[IDX_W-1:0];
			ST_CMP: begin
				we_c    = 1'b1;
				wdata_c = cmp_res.moved ? cmp_res.big_value : v_q;
			end
			ST_XST:  raddr_c = i_dec[IDX_W-1:0];
			ST_X2: begin
				we_c    = 1'b1;
				waddr_c = i_dec[IDX_W-1:0];
				wdata_c = rdata;
			end
			ST_ORD:  raddr_c = i_q[IDX_W-1:0];
			default: raddr_c = '0;
		endcase
	end

	hsort_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ELEMENTS)
	) u_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.raddr (raddr_c),
		.rdata (rdata)
	);

	hsort_cmp u_cmp (
		.clk        (clk),
		.ctl        (cmp_ctl),
		.rd_data    (rdata),
		.hold_value (v_q),
		.res        (cmp_res)
	);

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			hs_q        <= '0;
			pos_q       <= '0;
			extract_q   <= 1'b0;
			r_ok_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				// collect values, drop those beyond the store
				ST_LOAD: begin
					if (in_xfer) begin
						cnt_q <= n_next;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (item.in_last) begin
							n_q       <= n_next;
							i_q       <= n_next >> 1;
							extract_q <= 1'b0;
							state_q   <= ST_BLD;
						end
					end
				end
				// next node of the bottom-up build
				ST_BLD: begin
					if (i_q == '0) begin
						i_q       <= n_q;
						extract_q <= 1'b1;
						state_q   <= ST_XST;
					end else begin
						pos_q   <= i_dec[IDX_W-1:0];
						hs_q    <= n_q;
						state_q <= ST_GETV;
					end
				end
				ST_GETV: state_q <= ST_RDL;
				// sift level: stop at a leaf
				ST_RDL: begin
					if (l_idx >= hs_ext) begin
						i_q     <= i_dec;
						state_q <= extract_q ? ST_XST : ST_BLD;
					end else begin
						state_q <= ST_RDR;
					end
				end
				ST_RDR: begin
					r_ok_q  <= (r_idx < hs_ext);
					state_q <= ST_CMP;
				end
				// move the larger child up or settle the held value
				ST_CMP: begin
					if (cmp_res.moved) begin
						pos_q   <= cmp_res.take_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
						state_q <= ST_RDL;
					end else begin
						i_q     <= i_dec;
						state_q <= extract_q ? ST_XST : ST_BLD;
					end
				end
				// swap root with the end of the shrinking heap
				ST_XST: begin
					if (i_q <= CNT_W'(1)) begin
						i_q     <= '0;
						state_q <= ST_ORD;
					end else begin
						state_q <= ST_X1;
					end
				end
				ST_X1: state_q <= ST_X2;
				ST_X2: begin
					hs_q    <= i_dec;
					pos_q   <= '0;
					state_q <= ST_RDL;
				end
				// emit sorted values
				ST_ORD: state_q <= ST_OLD;
				ST_OLD: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_OWT;
				end
				ST_OWT: begin
					if (out_xfer) begin
						res_valid_q <= 1'b0;
						if (res_q.out_last) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// hold value of the sift and the output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_GETV || state_q == ST_X1) begin
			v_q <= rdata;
		end
		if (state_q == ST_OLD) begin
			res_q.out_value    <= rdata;
			res_q.out_last     <= (i_q + CNT_W'(1) == n_q);
			res_q.out_overflow <= ovf_q;
		end
	end

endmodule

>>> rtl/hsort_chk.sv
// ----------------------------------------------------------------------------
// hsort_chk
// Port-level checks of the heap sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module hsort_chk import hsort_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// no input while a result is pending
	a_no_in_on_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("input open while result pending");

	// a non-last item causes no result and leaves the input open
	a_quiet_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !item.in_last |=> !result_valid && !item_stall)
		else $error("unexpected activity after non-last item");

	// the set keeps draining until its last result
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.out_last |=> item_stall)
		else $error("input opened before last result");

endmodule

bind heap_sort_engine_core hsort_chk u_hsort_chk (.*);
